[src/crast_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crast_pkg: shared constants for the circle rasterizer
// Default widths, action codes, slot limits and queue depth.
// ----------------------------------------------------------------------------
package crast_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 11;
    localparam int COLOUR_BITS     = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int SLOT_BITS       = 3;

    localparam logic       ACT_START    = 1'b0;
    localparam logic       ACT_STEP     = 1'b1;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic [SLOT_BITS-1:0] OUTLINE_LAST = 3'd7;
    localparam logic [SLOT_BITS-1:0] FILL_LAST    = 3'd3;

endpackage
`default_nettype wire

[src/crast_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crast_front: circle state and iteration update
// Latches a circle on start, and on each step pushes the current offsets as
// a job and advances the error term and offsets by the Andres rule.
// ----------------------------------------------------------------------------
module crast_front #(
    parameter int COORD_BITS  = crast_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = crast_pkg::RADIUS_BITS_DEF,
    parameter int JOB_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 3
                                + crast_pkg::COLOUR_BITS + 2
)(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          action,
    input  wire logic [COORD_BITS-1:0]         center_x,
    input  wire logic [COORD_BITS-1:0]         center_y,
    input  wire logic [RADIUS_BITS-1:0]        radius,
    input  wire logic                          fill_mode,
    input  wire logic [crast_pkg::COLOUR_BITS-1:0] rgba,
    output logic                               job_valid,
    input  wire logic                          job_ready,
    output logic [JOB_W-1:0]                   job
);

    localparam int XW = RADIUS_BITS + 1;
    localparam int YW = RADIUS_BITS + 2;
    localparam int DW = RADIUS_BITS + 3;
    localparam logic signed [DW-1:0] D_ONE = DW'(1);

    logic                              busy_reg, busy_next;
    logic [COORD_BITS-1:0]             cx_reg, cx_next;
    logic [COORD_BITS-1:0]             cy_reg, cy_next;
    logic [RADIUS_BITS-1:0]            rad_reg, rad_next;
    logic                              filled_reg, filled_next;
    logic [crast_pkg::COLOUR_BITS-1:0] colour_reg, colour_next;
    logic signed [DW-1:0]              d_reg, d_next;
    logic [XW-1:0]                     x_reg, x_next;
    logic signed [YW-1:0]              y_reg, y_next;

    logic                 accept;
    logic                 step_go;
    logic signed [DW-1:0] x_ext;
    logic signed [DW-1:0] y_ext;
    logic signed [DW-1:0] r_ext;
    logic signed [DW-1:0] two_x;
    logic signed [DW-1:0] two_rmy;
    logic signed [DW-1:0] d_upd;
    logic [XW-1:0]        x_upd;
    logic signed [YW-1:0] y_upd;
    logic                 done_upd;

    assign in_ready  = job_ready;
    assign accept    = in_valid && in_ready;
    assign step_go   = accept && (action == crast_pkg::ACT_STEP) && busy_reg;
    assign job_valid = step_go;

    assign x_ext   = $signed({{(DW - XW){1'b0}}, x_reg});
    assign y_ext   = $signed({{(DW - YW){y_reg[YW-1]}}, y_reg});
    assign r_ext   = $signed({{(DW - RADIUS_BITS){1'b0}}, rad_reg});
    assign two_x   = x_ext <<< 1;
    assign two_rmy = (r_ext - y_ext) <<< 1;

    // three-way andres update
    always_comb
    begin
        d_upd = d_reg;
        x_upd = x_reg;
        y_upd = y_reg;
        if (d_reg >= two_x)
        begin
            d_upd = d_reg - two_x - D_ONE;
            x_upd = x_reg + XW'(1);
        end
        else if (d_reg < two_rmy)
        begin
            d_upd = d_reg + (y_ext <<< 1) - D_ONE;
            y_upd = y_reg - YW'(1);
        end
        else
        begin
            d_upd = d_reg + ((y_ext - x_ext - D_ONE) <<< 1);
            x_upd = x_reg + XW'(1);
            y_upd = y_reg - YW'(1);
        end
    end

    assign done_upd = y_upd < $signed({1'b0, x_upd});

    assign job = {done_upd, colour_reg, filled_reg, y_reg, x_reg, cy_reg, cx_reg};

    always_comb
    begin
        busy_next   = busy_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        rad_next    = rad_reg;
        filled_next = filled_reg;
        colour_next = colour_reg;
        d_next      = d_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        if (accept && (action == crast_pkg::ACT_START))
        begin
            busy_next   = 1'b1;
            cx_next     = center_x;
            cy_next     = center_y;
            rad_next    = radius;
            filled_next = fill_mode;
            colour_next = rgba;
            d_next      = $signed({{(DW - RADIUS_BITS){1'b0}}, radius}) - D_ONE;
            x_next      = '0;
            y_next      = $signed({{(YW - RADIUS_BITS){1'b0}}, radius});
        end
        else if (step_go)
        begin
            busy_next = !done_upd;
            d_next    = d_upd;
            x_next    = x_upd;
            y_next    = y_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            rad_reg    <= '0;
            filled_reg <= 1'b0;
            colour_reg <= '0;
            d_reg      <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            rad_reg    <= rad_next;
            filled_reg <= filled_next;
            colour_reg <= colour_next;
            d_reg      <= d_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
        end
    end

    // offsets of a running circle never cross
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (y_reg >= $signed({1'b0, x_reg})))
        else $error("front: running circle with y below x");

endmodule
`default_nettype wire

[src/crast_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crast_queue: job queue between front and back
// Small first-in first-out buffer that lets both sides stall independently.
// ----------------------------------------------------------------------------
module crast_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = crast_pkg::QUEUE_DEPTH
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push;
    logic             pop;

    assign wr_ready = count_reg != CW'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue: fill count past depth");

endmodule
`default_nettype wire

[src/crast_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crast_back: point and span emitter
// Walks one job through its eight outline points or four fill spans, one
// result a cycle unless the output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module crast_back #(
    parameter int COORD_BITS  = crast_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = crast_pkg::RADIUS_BITS_DEF,
    parameter int JOB_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 3
                                + crast_pkg::COLOUR_BITS + 2,
    parameter int OUT_BITS    = COORD_BITS + 2
)(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          job_valid,
    output logic                               job_ready,
    input  wire logic [JOB_W-1:0]              job,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [OUT_BITS-1:0]                span_y,
    output logic [OUT_BITS-1:0]                span_left,
    output logic [OUT_BITS-1:0]                span_right,
    output logic [crast_pkg::COLOUR_BITS-1:0]  pixel_colour,
    output logic                               opaque,
    output logic                               step_last,
    output logic                               circle_done
);

    localparam int XW = RADIUS_BITS + 1;
    localparam int YW = RADIUS_BITS + 2;
    localparam int MW = (COORD_BITS > YW) ? COORD_BITS : YW;
    localparam int SW = MW + 2;
    localparam int SB = crast_pkg::SLOT_BITS;

    localparam int CX_LO  = 0;
    localparam int CY_LO  = CX_LO + COORD_BITS;
    localparam int X_LO   = CY_LO + COORD_BITS;
    localparam int Y_LO   = X_LO + XW;
    localparam int F_LO   = Y_LO + YW;
    localparam int COL_LO = F_LO + 1;
    localparam int DN_LO  = COL_LO + crast_pkg::COLOUR_BITS;

    logic                              busy_reg, busy_next;
    logic [SB-1:0]                     slot_reg, slot_next;
    logic [JOB_W-1:0]                  job_reg, job_next;
    logic                              valid_reg, valid_next;
    logic [OUT_BITS-1:0]               row_reg, row_next;
    logic [OUT_BITS-1:0]               left_reg, left_next;
    logic [OUT_BITS-1:0]               right_reg, right_next;
    logic [crast_pkg::COLOUR_BITS-1:0] colour_reg, colour_next;
    logic                              opaque_reg, opaque_next;
    logic                              last_reg, last_next;
    logic                              done_reg, done_next;

    logic                 emit;
    logic                 slot_end;
    logic                 filled;
    logic signed [SW-1:0] cx, cy, ox, oy;
    logic signed [SW-1:0] cy_px, cy_py, cy_mx, cy_my;
    logic signed [SW-1:0] cx_px, cx_py, cx_mx, cx_my;
    logic signed [SW-1:0] row_s, left_s, right_s;

    assign filled = job_reg[F_LO];
    assign cx = $signed({{(SW - COORD_BITS){1'b0}}, job_reg[CX_LO +: COORD_BITS]});
    assign cy = $signed({{(SW - COORD_BITS){1'b0}}, job_reg[CY_LO +: COORD_BITS]});
    assign ox = $signed({{(SW - XW){1'b0}}, job_reg[X_LO +: XW]});
    assign oy = $signed({{(SW - YW){job_reg[Y_LO + YW - 1]}}, job_reg[Y_LO +: YW]});

    assign cy_px = cy + ox;
    assign cy_py = cy + oy;
    assign cy_mx = cy - ox;
    assign cy_my = cy - oy;
    assign cx_px = cx + ox;
    assign cx_py = cx + oy;
    assign cx_mx = cx - ox;
    assign cx_my = cx - oy;

    always_comb
    begin
        row_s   = cy_py;
        left_s  = cx_px;
        right_s = cx_px;
        if (filled)
        begin
            case (slot_reg[1:0])
                2'd0:
                begin
                    row_s = cy_px; left_s = cx_my; right_s = cx_py;
                end
                2'd1:
                begin
                    row_s = cy_py; left_s = cx_mx; right_s = cx_px;
                end
                2'd2:
                begin
                    row_s = cy_my; left_s = cx_mx; right_s = cx_px;
                end
                default:
                begin
                    row_s = cy_mx; left_s = cx_my; right_s = cx_py;
                end
            endcase
        end
        else
        begin
            case (slot_reg)
                3'd0:    begin row_s = cy_py; left_s = cx_px; end
                3'd1:    begin row_s = cy_px; left_s = cx_py; end
                3'd2:    begin row_s = cy_py; left_s = cx_mx; end
                3'd3:    begin row_s = cy_px; left_s = cx_my; end
                3'd4:    begin row_s = cy_my; left_s = cx_px; end
                3'd5:    begin row_s = cy_mx; left_s = cx_py; end
                3'd6:    begin row_s = cy_my; left_s = cx_mx; end
                default: begin row_s = cy_mx; left_s = cx_my; end
            endcase
            right_s = left_s;
        end
    end

    assign emit      = busy_reg && (!valid_reg || out_ready);
    assign slot_end  = slot_reg == (filled ? crast_pkg::FILL_LAST : crast_pkg::OUTLINE_LAST);
    assign job_ready = !busy_reg || (emit && slot_end);

    always_comb
    begin
        busy_next   = busy_reg;
        slot_next   = slot_reg;
        job_next    = job_reg;
        valid_next  = valid_reg && !out_ready;
        row_next    = row_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        colour_next = colour_reg;
        opaque_next = opaque_reg;
        last_next   = last_reg;
        done_next   = done_reg;
        if (emit)
        begin
            valid_next  = 1'b1;
            row_next    = row_s[OUT_BITS-1:0];
            left_next   = left_s[OUT_BITS-1:0];
            right_next  = right_s[OUT_BITS-1:0];
            colour_next = job_reg[COL_LO +: crast_pkg::COLOUR_BITS];
            opaque_next = job_reg[COL_LO +: 8] == crast_pkg::ALPHA_OPAQUE;
            last_next   = slot_end;
            done_next   = slot_end && job_reg[DN_LO];
            slot_next   = slot_reg + SB'(1);
        end
        if (job_ready)
        begin
            busy_next = job_valid;
            job_next  = job;
            slot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            slot_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        row_reg    <= row_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        colour_reg <= colour_next;
        opaque_reg <= opaque_next;
        last_reg   <= last_next;
        done_reg   <= done_next;
    end

    assign out_valid    = valid_reg;
    assign span_y       = row_reg;
    assign span_left    = left_reg;
    assign span_right   = right_reg;
    assign pixel_colour = colour_reg;
    assign opaque       = opaque_reg;
    assign step_last    = last_reg;
    assign circle_done  = done_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && done_reg) |-> last_reg)
        else $error("back: circle end not on last transaction of a step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && filled) |-> (slot_reg <= crast_pkg::FILL_LAST))
        else $error("back: fill slot out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(row_reg) && $stable(last_reg)))
        else $error("back: stalled result changed");

endmodule
`default_nettype wire

[src/circle_rasterizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_rasterizer: Andres circle rasterizer
// Outline points or filled horizontal spans of a circle, one step at a time.
//
// s_* channel: one transaction per command. tuser is the action: start loads
//   center, radius, fill mode and colour and emits nothing; step runs one
//   iteration of the circle loop. Steps with no circle running emit nothing.
// m_* channel: one transaction per point (outline, 8 per step) or span
//   (fill, 4 per step). tlast marks the last transaction of a step, tuser[1]
//   the end of the circle.
// path: job queue, then the back end's job register, then the output stage.
// throughput: one result per cycle while the output is not stalled; set by
//   the single emitter in the back end. The front end takes a command per
//   cycle while the 2-entry job queue has room.
// reset: no circle running, queue and output stage empty.
// stall: results hold on m_tdata; the queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module circle_rasterizer #(
    parameter int COORD_BITS  = crast_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = crast_pkg::RADIUS_BITS_DEF
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // center_x, center_y, radius, fill_mode, rgba, zero fill
    input  wire logic [((2 * COORD_BITS + RADIUS_BITS + 1 + crast_pkg::COLOUR_BITS + 7)
                        / 8) * 8 - 1:0] s_tdata,
    // action
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // span_y, span_left, span_right, pixel_colour, zero fill
    output logic [((3 * (COORD_BITS + 2) + crast_pkg::COLOUR_BITS + 7) / 8) * 8 - 1:0]
                                        m_tdata,
    // opaque, circle_done
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast
);

    localparam int CB     = crast_pkg::COLOUR_BITS;
    localparam int OUT_W  = COORD_BITS + 2;
    localparam int IN_W   = 2 * COORD_BITS + RADIUS_BITS + 1 + CB;
    localparam int OUT_PW = 3 * OUT_W + CB;
    localparam int OUT_DW = ((OUT_PW + 7) / 8) * 8;
    localparam int JOB_W  = 2 * COORD_BITS + 2 * RADIUS_BITS + 3 + CB + 2;

    logic                   q_in_valid, q_in_ready;
    logic [JOB_W-1:0]       q_in_data;
    logic                   q_out_valid, q_out_ready;
    logic [JOB_W-1:0]       q_out_data;
    logic [OUT_W-1:0]       span_y, span_left, span_right;
    logic [CB-1:0]          pixel_colour;
    logic                   opaque, step_last, circle_done;

    crast_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .JOB_W       (JOB_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .action    (s_tuser),
        .center_x  (s_tdata[COORD_BITS-1:0]),
        .center_y  (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .radius    (s_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
        .fill_mode (s_tdata[2*COORD_BITS+RADIUS_BITS]),
        .rgba      (s_tdata[IN_W-1:IN_W-CB]),
        .job_valid (q_in_valid),
        .job_ready (q_in_ready),
        .job       (q_in_data)
    );

    crast_queue #(
        .WIDTH (JOB_W),
        .DEPTH (crast_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .wr_data  (q_in_data),
        .rd_valid (q_out_valid),
        .rd_ready (q_out_ready),
        .rd_data  (q_out_data)
    );

    crast_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .JOB_W       (JOB_W),
        .OUT_BITS    (OUT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_out_valid),
        .job_ready    (q_out_ready),
        .job          (q_out_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .span_y       (span_y),
        .span_left    (span_left),
        .span_right   (span_right),
        .pixel_colour (pixel_colour),
        .opaque       (opaque),
        .step_last    (step_last),
        .circle_done  (circle_done)
    );

    assign m_tdata = {{(OUT_DW - OUT_PW){1'b0}}, pixel_colour, span_right, span_left, span_y};
    assign m_tuser = {circle_done, opaque};
    assign m_tlast = step_last;

endmodule
`default_nettype wire
